// ===== rtl/prqe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prqe_pkg
// shared widths, types and codes of the polyline ribbon quad expander
// ----------------------------------------------------------------------------
package prqe_pkg;

    localparam int COORD_BITS = 32;
    localparam int UNIT_BITS  = 16;

    localparam int MAG_W   = COORD_BITS + 1;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int ROOT_W  = COORD_BITS + 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int QUO_W   = UNIT_BITS - 1;
    localparam int CNT_W   = $clog2(MAG_W + 1);
    localparam int ADDR_W  = 2;
    localparam int ARC_W   = COORD_BITS + 2;

    localparam logic [ADDR_W-1:0] REG_Z_LEVEL = ADDR_W'(0);
    localparam logic [QUO_W-1:0]  UNIT_MAX    = {QUO_W{1'b1}};

    localparam logic [2:0] VX_A  = 3'd0;
    localparam logic [2:0] VX_B  = 3'd1;
    localparam logic [2:0] VX_C0 = 3'd2;
    localparam logic [2:0] VX_C1 = 3'd3;
    localparam logic [2:0] VX_B1 = 3'd4;
    localparam logic [2:0] VX_D  = 3'd5;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [UNIT_BITS-1:0]  t_unit;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
    } t_seg_req;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] len;
        logic [QUO_W-1:0]  qx;
        logic [QUO_W-1:0]  qy;
    } t_seg_rsp;

endpackage

// ===== rtl/prqe_point_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prqe_point_if
// input point channel
// ----------------------------------------------------------------------------
interface prqe_point_if;
    logic            valid;
    logic            ready;
    prqe_pkg::t_coord point_x;
    prqe_pkg::t_coord point_y;
    logic            chain_start;
    logic            chain_end;
    logic            chain_closed;

    modport source (output valid, point_x, point_y, chain_start, chain_end, chain_closed,
                    input ready);
    modport sink   (input valid, point_x, point_y, chain_start, chain_end, chain_closed,
                    output ready);
endinterface

// ===== rtl/prqe_vert_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prqe_vert_if
// output vertex channel
// ----------------------------------------------------------------------------
interface prqe_vert_if;
    logic                                valid;
    logic                                ready;
    prqe_pkg::t_coord                    vert_x;
    prqe_pkg::t_coord                    vert_y;
    prqe_pkg::t_coord                    vert_z;
    prqe_pkg::t_unit                     normal_x;
    prqe_pkg::t_unit                     normal_y;
    prqe_pkg::t_unit                     cap_x;
    prqe_pkg::t_unit                     cap_y;
    logic [prqe_pkg::COORD_BITS-1:0]     arc_pos;
    logic                                last_of_run;

    modport source (output valid, vert_x, vert_y, vert_z, normal_x, normal_y, cap_x, cap_y,
                    arc_pos, last_of_run, input ready);
    modport sink   (input valid, vert_x, vert_y, vert_z, normal_x, normal_y, cap_x, cap_y,
                    arc_pos, last_of_run, output ready);
endinterface

// ===== rtl/prqe_seg_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prqe_seg_unit
// bit-serial squares, restoring square root and two tangent divisions
// ----------------------------------------------------------------------------
module prqe_seg_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  prqe_pkg::t_seg_req   i_req,
    output prqe_pkg::t_seg_rsp   o_rsp
);

    typedef enum logic [5:0] {
        U_IDLE = 6'b000001,
        U_MUL  = 6'b000010,
        U_SQRT = 6'b000100,
        U_RND  = 6'b001000,
        U_DIV  = 6'b010000,
        U_FIN  = 6'b100000
    } t_ustate;

    t_ustate                         r_st;
    logic [prqe_pkg::CNT_W-1:0]      r_cnt;
    logic [prqe_pkg::MAG_W-1:0]      r_mx, r_my, r_ax, r_ay;
    logic [prqe_pkg::SQ_W-1:0]       r_ax_sh, r_ay_sh, r_acc;
    logic [prqe_pkg::ROOT_W-1:0]     r_root, r_rx, r_ry;
    logic [prqe_pkg::REM_W-1:0]      r_rem;
    logic [prqe_pkg::QUO_W-1:0]      r_qx, r_qy;
    logic                            r_satx, r_saty, r_done;

    logic [prqe_pkg::REM_W-1:0]      n_rem_sh, n_trial;
    logic [prqe_pkg::ROOT_W-1:0]     n_len;
    logic [prqe_pkg::ROOT_W:0]       n_tx, n_ty, n_lenx;
    logic [prqe_pkg::QUO_W:0]        n_qx1, n_qy1;

    assign n_rem_sh = {r_rem[prqe_pkg::REM_W-3:0], r_acc[prqe_pkg::SQ_W-1 -: 2]};
    assign n_trial  = {r_root, 2'b01};
    assign n_len    = r_root + prqe_pkg::ROOT_W'(r_rem > {2'b00, r_root});
    assign n_lenx   = {1'b0, r_root};
    assign n_tx     = {r_rx, 1'b0};
    assign n_ty     = {r_ry, 1'b0};
    assign n_qx1    = {1'b0, r_qx} + (prqe_pkg::QUO_W+1)'(1);
    assign n_qy1    = {1'b0, r_qy} + (prqe_pkg::QUO_W+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= U_IDLE;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                U_IDLE: begin
                    if (i_req.start) begin
                        r_mx    <= i_req.ax;
                        r_my    <= i_req.ay;
                        r_ax    <= i_req.ax;
                        r_ay    <= i_req.ay;
                        r_ax_sh <= prqe_pkg::SQ_W'(i_req.ax);
                        r_ay_sh <= prqe_pkg::SQ_W'(i_req.ay);
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_st    <= U_MUL;
                    end
                end
                U_MUL: begin
                    r_acc   <= r_acc + (r_mx[0] ? r_ax_sh : '0) + (r_my[0] ? r_ay_sh : '0);
                    r_ax_sh <= r_ax_sh << 1;
                    r_ay_sh <= r_ay_sh << 1;
                    r_mx    <= r_mx >> 1;
                    r_my    <= r_my >> 1;
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == prqe_pkg::CNT_W'(prqe_pkg::MAG_W - 1)) begin
                        r_cnt  <= '0;
                        r_rem  <= '0;
                        r_root <= '0;
                        r_st   <= U_SQRT;
                    end
                end
                U_SQRT: begin
                    if (n_rem_sh >= n_trial) begin
                        r_rem  <= n_rem_sh - n_trial;
                        r_root <= {r_root[prqe_pkg::ROOT_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= n_rem_sh;
                        r_root <= {r_root[prqe_pkg::ROOT_W-2:0], 1'b0};
                    end
                    r_acc <= r_acc << 2;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == prqe_pkg::CNT_W'(prqe_pkg::MAG_W - 1)) begin
                        r_cnt <= '0;
                        r_st  <= U_RND;
                    end
                end
                U_RND: begin
                    r_root <= n_len;
                    r_rx   <= prqe_pkg::ROOT_W'(r_ax);
                    r_ry   <= prqe_pkg::ROOT_W'(r_ay);
                    r_satx <= prqe_pkg::ROOT_W'(r_ax) >= n_len;
                    r_saty <= prqe_pkg::ROOT_W'(r_ay) >= n_len;
                    r_qx   <= '0;
                    r_qy   <= '0;
                    r_st   <= U_DIV;
                end
                U_DIV: begin
                    if (n_tx >= n_lenx) begin
                        r_rx <= prqe_pkg::ROOT_W'(n_tx - n_lenx);
                        r_qx <= {r_qx[prqe_pkg::QUO_W-2:0], 1'b1};
                    end else begin
                        r_rx <= prqe_pkg::ROOT_W'(n_tx);
                        r_qx <= {r_qx[prqe_pkg::QUO_W-2:0], 1'b0};
                    end
                    if (n_ty >= n_lenx) begin
                        r_ry <= prqe_pkg::ROOT_W'(n_ty - n_lenx);
                        r_qy <= {r_qy[prqe_pkg::QUO_W-2:0], 1'b1};
                    end else begin
                        r_ry <= prqe_pkg::ROOT_W'(n_ty);
                        r_qy <= {r_qy[prqe_pkg::QUO_W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == prqe_pkg::CNT_W'(prqe_pkg::QUO_W - 1)) begin
                        r_cnt <= '0;
                        r_st  <= U_FIN;
                    end
                end
                U_FIN: begin
                    if (r_satx || (n_tx >= n_lenx && n_qx1[prqe_pkg::QUO_W]))
                        r_qx <= prqe_pkg::UNIT_MAX;
                    else if (n_tx >= n_lenx)
                        r_qx <= n_qx1[prqe_pkg::QUO_W-1:0];
                    if (r_saty || (n_ty >= n_lenx && n_qy1[prqe_pkg::QUO_W]))
                        r_qy <= prqe_pkg::UNIT_MAX;
                    else if (n_ty >= n_lenx)
                        r_qy <= n_qy1[prqe_pkg::QUO_W-1:0];
                    r_done <= 1'b1;
                    r_st   <= U_IDLE;
                end
                default: r_st <= U_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.len  = r_root;
    assign o_rsp.qx   = r_qx;
    assign o_rsp.qy   = r_qy;

endmodule

// ===== rtl/polyline_ribbon_quad_expander.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_ribbon_quad_expander
// expands polyline points into six-vertex quads per segment
// ----------------------------------------------------------------------------
// points enter on i_point, one word per valid/ready handshake; vertices leave
// on o_vert, six words per nonzero segment, last_of_run on the final word of
// each input point. z_level is written through the apb port at address 0.
// a point that opens a chain is taken and gives no word.
// a segment runs through the serial unit: setup, bit-serial squaring,
// restoring square root, rounding of the length and the two tangent
// divisions, then the six words are handed out. a closing point with two
// nonzero segments runs the unit twice. the arithmetic unit and the single
// vertex register set the rate. a new point is taken once the last word of
// the previous one sits in the output register, so that word and the next
// computation overlap. reset closes any chain, clears the arc total and
// z_level and empties the output register. a stalled receiver holds the
// output word and the sequencer waits at the next word; nothing is dropped.
// ----------------------------------------------------------------------------
module polyline_ribbon_quad_expander (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [prqe_pkg::ADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    prqe_point_if.sink                        i_point,
    prqe_vert_if.source                       o_vert
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state                              r_state, n_state;
    prqe_pkg::t_coord                    r_prev_x, r_prev_y, r_first_x, r_first_y, r_z;
    prqe_pkg::t_coord                    r_x0, r_y0, r_x1, r_y1;
    logic [prqe_pkg::COORD_BITS-1:0]     r_arc, r_arc0, r_arc1;
    logic                                r_in_chain, r_more, r_req_start;
    logic [2:0]                          r_k;
    prqe_pkg::t_unit                     r_tx, r_ty;

    logic                                r_ov, r_olast;
    prqe_pkg::t_coord                    r_ox, r_oy;
    prqe_pkg::t_unit                     r_onx, r_ony, r_ocx, r_ocy;
    logic [prqe_pkg::COORD_BITS-1:0]     r_oarc;

    prqe_pkg::t_seg_req                  w_req;
    prqe_pkg::t_seg_rsp                  w_rsp;

    logic                                w_acc, w_load, w_seg0_nz, w_cls_nz, w_is_end, w_neg;
    logic signed [prqe_pkg::COORD_BITS:0] w_dx, w_dy;
    logic [prqe_pkg::ARC_W-1:0]          w_arc_sum;
    prqe_pkg::t_unit                     w_tx, w_ty, w_nx, w_ny;

    assign pready = 1'b1;
    assign prdata = (paddr == prqe_pkg::REG_Z_LEVEL) ? 32'(r_z) : 32'd0;

    assign i_point.ready = (r_state == S_IDLE);
    assign w_acc = i_point.valid && i_point.ready;

    assign w_seg0_nz = (i_point.point_x != r_prev_x) || (i_point.point_y != r_prev_y);
    assign w_cls_nz  = i_point.chain_end && i_point.chain_closed &&
                       ((i_point.point_x != r_first_x) || (i_point.point_y != r_first_y));

    assign w_dx = (prqe_pkg::COORD_BITS+1)'(r_x1) - (prqe_pkg::COORD_BITS+1)'(r_x0);
    assign w_dy = (prqe_pkg::COORD_BITS+1)'(r_y1) - (prqe_pkg::COORD_BITS+1)'(r_y0);

    assign w_req.start = r_req_start;
    assign w_req.ax    = w_dx[prqe_pkg::COORD_BITS] ? prqe_pkg::MAG_W'(-w_dx)
                                                    : prqe_pkg::MAG_W'(w_dx);
    assign w_req.ay    = w_dy[prqe_pkg::COORD_BITS] ? prqe_pkg::MAG_W'(-w_dy)
                                                    : prqe_pkg::MAG_W'(w_dy);

    prqe_seg_unit u_seg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_tx = w_dx[prqe_pkg::COORD_BITS] ? -prqe_pkg::UNIT_BITS'({1'b0, w_rsp.qx})
                                             :  prqe_pkg::UNIT_BITS'({1'b0, w_rsp.qx});
    assign w_ty = w_dy[prqe_pkg::COORD_BITS] ? -prqe_pkg::UNIT_BITS'({1'b0, w_rsp.qy})
                                             :  prqe_pkg::UNIT_BITS'({1'b0, w_rsp.qy});
    assign w_arc_sum = prqe_pkg::ARC_W'(r_arc) + prqe_pkg::ARC_W'(w_rsp.len);

    assign w_nx = -r_ty;
    assign w_ny = r_tx;

    always_comb begin
        case (r_k)
            prqe_pkg::VX_A:  begin w_is_end = 1'b0; w_neg = 1'b0; end
            prqe_pkg::VX_B:  begin w_is_end = 1'b0; w_neg = 1'b1; end
            prqe_pkg::VX_C0: begin w_is_end = 1'b1; w_neg = 1'b0; end
            prqe_pkg::VX_C1: begin w_is_end = 1'b1; w_neg = 1'b0; end
            prqe_pkg::VX_B1: begin w_is_end = 1'b0; w_neg = 1'b1; end
            prqe_pkg::VX_D:  begin w_is_end = 1'b1; w_neg = 1'b1; end
            default:         begin w_is_end = 1'b0; w_neg = 1'b0; end
        endcase
    end

    assign w_load = (r_state == S_EMIT) && (!r_ov || o_vert.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc && !(i_point.chain_start || !r_in_chain) && (w_seg0_nz || w_cls_nz))
                    n_state = S_CALC;
            end
            S_CALC: begin
                if (w_rsp.done)
                    n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_load && r_k == prqe_pkg::VX_D)
                    n_state = r_more ? S_CALC : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_first_x   <= '0;
            r_first_y   <= '0;
            r_arc       <= '0;
            r_in_chain  <= 1'b0;
            r_z         <= '0;
            r_more      <= 1'b0;
            r_req_start <= 1'b0;
            r_k         <= prqe_pkg::VX_A;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_req_start <= 1'b0;

            if (psel && penable && pwrite && pready && paddr == prqe_pkg::REG_Z_LEVEL)
                r_z <= prqe_pkg::t_coord'(pwdata);

            if (w_acc) begin
                r_prev_x <= i_point.point_x;
                r_prev_y <= i_point.point_y;
                if (i_point.chain_start || !r_in_chain) begin
                    r_first_x  <= i_point.point_x;
                    r_first_y  <= i_point.point_y;
                    r_arc      <= '0;
                    r_in_chain <= !i_point.chain_end;
                end else begin
                    if (i_point.chain_end)
                        r_in_chain <= 1'b0;
                    if (w_seg0_nz) begin
                        r_x0   <= r_prev_x;
                        r_y0   <= r_prev_y;
                        r_x1   <= i_point.point_x;
                        r_y1   <= i_point.point_y;
                        r_more <= w_cls_nz;
                    end else begin
                        r_x0   <= i_point.point_x;
                        r_y0   <= i_point.point_y;
                        r_x1   <= r_first_x;
                        r_y1   <= r_first_y;
                        r_more <= 1'b0;
                    end
                    r_req_start <= w_seg0_nz || w_cls_nz;
                end
            end

            if (r_state == S_CALC && w_rsp.done) begin
                r_tx   <= w_tx;
                r_ty   <= w_ty;
                r_arc0 <= r_arc;
                if (w_arc_sum[prqe_pkg::ARC_W-1 -: 2] != 2'b00) begin
                    r_arc1 <= '1;
                    r_arc  <= '1;
                end else begin
                    r_arc1 <= w_arc_sum[prqe_pkg::COORD_BITS-1:0];
                    r_arc  <= w_arc_sum[prqe_pkg::COORD_BITS-1:0];
                end
                r_k <= prqe_pkg::VX_A;
            end

            if (o_vert.ready)
                r_ov <= 1'b0;

            if (w_load) begin
                r_ov    <= 1'b1;
                r_ox    <= w_is_end ? r_x1 : r_x0;
                r_oy    <= w_is_end ? r_y1 : r_y0;
                r_onx   <= w_neg ? -w_nx : w_nx;
                r_ony   <= w_neg ? -w_ny : w_ny;
                r_ocx   <= w_is_end ? r_tx : -r_tx;
                r_ocy   <= w_is_end ? r_ty : -r_ty;
                r_oarc  <= w_is_end ? r_arc1 : r_arc0;
                r_olast <= (r_k == prqe_pkg::VX_D) && !r_more;
                r_k     <= r_k + 3'd1;
                if (r_k == prqe_pkg::VX_D) begin
                    if (r_more) begin
                        r_x0        <= r_x1;
                        r_y0        <= r_y1;
                        r_x1        <= r_first_x;
                        r_y1        <= r_first_y;
                        r_more      <= 1'b0;
                        r_req_start <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_vert.valid       = r_ov;
    assign o_vert.vert_x      = r_ox;
    assign o_vert.vert_y      = r_oy;
    assign o_vert.vert_z      = r_z;
    assign o_vert.normal_x    = r_onx;
    assign o_vert.normal_y    = r_ony;
    assign o_vert.cap_x       = r_ocx;
    assign o_vert.cap_y       = r_ocy;
    assign o_vert.arc_pos     = r_oarc;
    assign o_vert.last_of_run = r_olast;

    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> r_state == S_CALC)
        else $error("segment result outside calc");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> w_rsp.len != '0)
        else $error("zero length for nonzero segment");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_k == prqe_pkg::VX_D && !r_more) |=> (o_vert.valid && o_vert.last_of_run))
        else $error("final word of run lacks last flag");

endmodule

// ===== tb/tb_polyline_ribbon_quad_expander.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polyline_ribbon_quad_expander
// self-checking bench for the polyline ribbon quad expander
// ----------------------------------------------------------------------------
// points go in on the point channel and a local predictor computes the
// expected vertex words of each one: length, tangent, normal, cap and arc.
// every vertex word that leaves is compared field by field with the oldest
// expected word. directed chains cover the special cases, random chains with
// some noise cover the rest, under several idle and stall patterns, with
// z_level written between phases.
// ----------------------------------------------------------------------------
module tb_polyline_ribbon_quad_expander;

    localparam int LIMIT = 20000;
    localparam logic [15:0] UMAG = 16'h7fff;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] cx;
        logic [15:0] cy;
        logic [31:0] arc;
        logic        last;
    } t_vert;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [prqe_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;

    prqe_point_if pt_if();
    prqe_vert_if  vx_if();

    polyline_ribbon_quad_expander dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_point(pt_if.sink), .o_vert(vx_if.source)
    );

    // predictor state
    logic signed [63:0] prv_x, prv_y, fst_x, fst_y;
    logic [63:0] arc_run;
    logic        chain_open;
    logic [31:0] z_cur;

    t_vert expected_verts[$];
    int    errors;
    int    words_seen;
    int    points_sent;
    int    idle_pct;
    int    stall_pct;
    bit    hold_off;
    int    quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] root_round(logic [127:0] s);
        logic [63:0] r;
        logic [63:0] c;
        logic [127:0] cc;
        r = 0;
        for (int b = 32; b >= 0; b--) begin
            c = r | (64'd1 << b);
            cc = c * c;
            if (cc <= s) r = c;
        end
        cc = r * r;
        if (s - cc > {64'd0, r}) r = r + 1;
        return r;
    endfunction

    function automatic logic [15:0] unit_quot(logic [63:0] num, logic [63:0] den);
        logic [63:0] q, rem;
        if (num >= den) return UMAG;
        q = 0;
        rem = num;
        for (int i = 0; i < 15; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den) begin
                rem = rem - den;
                q[0] = 1'b1;
            end
        end
        if (2 * rem >= den) q = q + 1;
        if (q > UMAG) q = UMAG;
        return q[15:0];
    endfunction

    function automatic t_vert mk_vert(logic signed [63:0] x, logic signed [63:0] y,
                                      logic [15:0] nx, logic [15:0] ny,
                                      logic [15:0] cx, logic [15:0] cy, logic [63:0] arc);
        t_vert v;
        v.x = x[31:0];
        v.y = y[31:0];
        v.z = z_cur;
        v.nx = nx;
        v.ny = ny;
        v.cx = cx;
        v.cy = cy;
        v.arc = arc[31:0];
        v.last = 1'b0;
        return v;
    endfunction

    task automatic quad_segment(logic signed [63:0] x0, logic signed [63:0] y0,
                                logic signed [63:0] x1, logic signed [63:0] y1,
                                inout t_vert run[$]);
        logic signed [63:0] dx, dy;
        logic [63:0] ax, ay, len, a0, a1;
        logic [15:0] tx, ty, nx, ny;
        dx = x1 - x0;
        dy = y1 - y0;
        if (dx == 0 && dy == 0) return;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        len = root_round({64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay});
        tx = unit_quot(ax, len);
        ty = unit_quot(ay, len);
        if (dx < 0) tx = -tx;
        if (dy < 0) ty = -ty;
        nx = -ty;
        ny = tx;
        a0 = arc_run;
        a1 = a0 + len;
        if (a1 > 64'hffff_ffff) a1 = 64'hffff_ffff;
        arc_run = a1;
        run = {run, mk_vert(x0, y0, nx, ny, -tx, -ty, a0)};
        run = {run, mk_vert(x0, y0, -nx, -ny, -tx, -ty, a0)};
        run = {run, mk_vert(x1, y1, nx, ny, tx, ty, a1)};
        run = {run, mk_vert(x1, y1, nx, ny, tx, ty, a1)};
        run = {run, mk_vert(x0, y0, -nx, -ny, -tx, -ty, a0)};
        run = {run, mk_vert(x1, y1, -nx, -ny, tx, ty, a1)};
    endtask

    task automatic predict_point(logic [31:0] px, logic [31:0] py, bit st, bit en, bit cl);
        logic signed [63:0] x, y;
        t_vert run[$];
        x = 64'($signed(px));
        y = 64'($signed(py));
        if (st || !chain_open) begin
            fst_x = x;
            prv_x = x;
            fst_y = y;
            prv_y = y;
            arc_run = 0;
            chain_open = !en;
            return;
        end
        quad_segment(prv_x, prv_y, x, y, run);
        prv_x = x;
        prv_y = y;
        if (en) begin
            if (cl) quad_segment(x, y, fst_x, fst_y, run);
            chain_open = 1'b0;
        end
        if (run.size() > 0) run[run.size()-1].last = 1'b1;
        expected_verts = {expected_verts, run};
    endtask

    task automatic send_point(logic [31:0] px, logic [31:0] py, bit st, bit en, bit cl);
        while (!hold_off && idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            pt_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_if.valid <= 1'b1;
        pt_if.point_x <= px;
        pt_if.point_y <= py;
        pt_if.chain_start <= st;
        pt_if.chain_end <= en;
        pt_if.chain_closed <= cl;
        do @(posedge i_clk); while (!pt_if.ready);
        predict_point(px, py, st, en, cl);
        points_sent++;
    endtask

    task automatic drain_all();
        pt_if.valid <= 1'b0;
        while (expected_verts.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_z(logic [31:0] val);
        drain_all();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= prqe_pkg::REG_Z_LEVEL;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        z_cur = val;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // mostly short coordinates, sometimes full width
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(7) - 3;
            default: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    task automatic test_directed();
        write_z(32'h8000_0000);
        send_point(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
        send_point(32'h0001_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
        send_point(32'h0001_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
        send_point(32'h0001_0000, 32'h0001_0000, 1'b0, 1'b1, 1'b1);
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 1'b0, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, 1'b0);
        send_point(32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b0, 1'b0);
        send_point(32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b0, 1'b0);
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 1'b1, 1'b1);
        send_point(32'h0000_0005, 32'h0000_0005, 1'b0, 1'b0, 1'b1);
        send_point(32'h0000_0006, 32'hffff_fffb, 1'b0, 1'b0, 1'b0);
        send_point(32'h0000_0006, 32'h0000_0003, 1'b1, 1'b1, 1'b1);
        send_point(32'h0000_0001, 32'h0000_0001, 1'b1, 1'b0, 1'b0);
        send_point(32'h0000_0002, 32'h0000_0001, 1'b0, 1'b0, 1'b0);
        send_point(32'h0000_0001, 32'h0000_0001, 1'b0, 1'b1, 1'b1);
        send_point(32'h0000_0003, 32'h0000_0003, 1'b0, 1'b1, 1'b0);
        write_z(32'h7fff_ffff);
        send_point(32'hffff_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
        send_point(32'hffff_0000, 32'h0000_0000, 1'b0, 1'b1, 1'b1);
        send_point(32'h0000_0003, 32'h0000_0004, 1'b1, 1'b0, 1'b0);
        send_point(32'hffff_fffd, 32'hffff_fffc, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic random_chains(int n_points);
        int left;
        int len;
        left = n_points;
        while (left > 0) begin
            if ($urandom_range(9) == 0) begin
                send_point(rand_coord(), rand_coord(), 1'($urandom), 1'($urandom),
                           1'($urandom));
                left--;
            end else begin
                len = $urandom_range(5, 2);
                send_point(rand_coord(), rand_coord(), 1'b1, 1'b0, 1'($urandom));
                for (int i = 1; i < len; i++)
                    send_point(rand_coord(), rand_coord(), 1'b0, i == len - 1, 1'($urandom));
                left -= len;
            end
        end
    endtask

    task automatic test_random_phases();
        idle_pct = 0;
        stall_pct = 0;
        random_chains(15);
        write_z($urandom);
        idle_pct = 57;
        random_chains(15);
        idle_pct = 0;
        stall_pct = 57;
        random_chains(15);
        write_z(32'h0000_0000);
        idle_pct = 12;
        stall_pct = 12;
        random_chains(15);
        idle_pct = 0;
        stall_pct = 0;
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (600) @(posedge i_clk);
                hold_off = 1'b0;
            end
            random_chains(12);
        join
        // sender waits for every word before going on
        drain_all();
        random_chains(6);
    endtask

    // receiver side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            vx_if.ready <= 1'b0;
        end else begin
            vx_if.ready <= !hold_off && !(stall_pct > 0 && $urandom_range(99) < stall_pct);
        end
    end

    // vertex checker and watchdog
    always @(posedge i_clk) begin
        t_vert got, exp_v;
        if (i_rst_n) begin
            if ((vx_if.valid && vx_if.ready) || (pt_if.valid && pt_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles > LIMIT) begin
                $display("%0t timeout", $time);
                $display("Verification failed");
                $finish;
            end
            if (vx_if.valid && vx_if.ready) begin
                got = '{vx_if.vert_x, vx_if.vert_y, vx_if.vert_z, vx_if.normal_x,
                        vx_if.normal_y, vx_if.cap_x, vx_if.cap_y, vx_if.arc_pos,
                        vx_if.last_of_run};
                words_seen++;
                if (expected_verts.size() == 0) begin
                    errors++;
                    $display("%0t unexpected word %h", $time, got);
                end else begin
                    exp_v = expected_verts.pop_front();
                    if (got !== exp_v) begin
                        errors++;
                        $display("%0t mismatch exp %h got %h", $time, exp_v, got);
                        $display("  x %h/%h y %h/%h z %h/%h n %h %h/%h %h",
                                 exp_v.x, got.x, exp_v.y, got.y, exp_v.z, got.z,
                                 exp_v.nx, exp_v.ny, got.nx, got.ny);
                        $display("  cap %h %h/%h %h arc %h/%h last %b/%b",
                                 exp_v.cx, exp_v.cy, got.cx, got.cy, exp_v.arc, got.arc,
                                 exp_v.last, got.last);
                    end
                end
            end
        end
    end

    initial begin
        errors = 0;
        words_seen = 0;
        points_sent = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_off = 1'b0;
        quiet_cycles = 0;
        prv_x = 0;
        prv_y = 0;
        fst_x = 0;
        fst_y = 0;
        arc_run = 0;
        chain_open = 1'b0;
        z_cur = 0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pt_if.valid = 1'b0;
        pt_if.point_x = '0;
        pt_if.point_y = '0;
        pt_if.chain_start = 1'b0;
        pt_if.chain_end = 1'b0;
        pt_if.chain_closed = 1'b0;
        vx_if.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phases();
        test_backpressure();
        drain_all();
        if (expected_verts.size() != 0) begin
            errors++;
            $display("%0t %0d words never arrived", $time, expected_verts.size());
        end
        $display("run covered %0d points and %0d vertex words over idle, stall and hold-off",
                 points_sent, words_seen);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
